@@ rtl/core/adbseq_pkg.sv @@
`default_nettype none
package adbseq_pkg;

	localparam int TICK_W = 20;
	localparam int KEPT_W = 4;
	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 20;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 32;

	localparam logic [KEPT_W-1:0] MAX_REPLY_BYTES = 4'd8;

	localparam logic [TICK_W-1:0] TIMEOUT_RESET = 20'd100000;
	localparam logic [KEPT_W-1:0] MAX_REPLY_RESET = 4'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_REPLY = 1'b1;

	// request kinds carried on tuser
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_POLL = 1'b1;

	// bus state line codes
	localparam logic [1:0] LINES_CMD = 2'd0;
	localparam logic [1:0] LINES_EVEN = 2'd1;
	localparam logic [1:0] LINES_ODD = 2'd2;
	localparam logic [1:0] LINES_IDLE = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_CMD = 2'd1,
		PH_REPLY = 2'd2
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic [TICK_W-1:0] tick;
		logic [KEPT_W-1:0] kept;
		logic odd;
	} seq_state_t;

	typedef struct packed {
		logic timed_out;
		logic [KEPT_W-1:0] reply_count;
		logic done_res;
		logic [BYTE_W-1:0] reply_byte;
		logic reply_valid;
		logic flag_clear;
		logic [BYTE_W-1:0] load_byte;
		logic load_strobe;
		logic shift_out_mode;
		logic [1:0] state_lines;
	} seq_result_t;

endpackage
`default_nettype wire

@@ rtl/core/adbseq_step.sv @@
`default_nettype none
module adbseq_step
	import adbseq_pkg::*;
(
	input  seq_state_t cur,
	input  logic req_type,
	input  logic [BYTE_W-1:0] command_byte,
	input  logic shift_flag,
	input  logic xcvr_line,
	input  logic [BYTE_W-1:0] shift_in_byte,
	input  logic [TICK_W-1:0] timeout_limit,
	input  logic [KEPT_W-1:0] max_reply,
	output seq_state_t nxt,
	output seq_result_t res
);

	logic [TICK_W:0] tick_inc;
	logic expired;
	logic [KEPT_W-1:0] cap;

	assign tick_inc = {1'b0, cur.tick} + {{TICK_W{1'b0}}, 1'b1};
	// a zero limit is caught here as well: any tick expires
	assign expired = (tick_inc >= {1'b0, timeout_limit});
	assign cap = (max_reply > MAX_REPLY_BYTES) ? MAX_REPLY_BYTES : max_reply;

	always_comb begin
		nxt = cur;
		res = '0;
		if (req_type == REQ_START) begin
			if (cur.phase == PH_IDLE) begin
				nxt.phase = PH_CMD;
				nxt.tick = '0;
				nxt.kept = '0;
				nxt.odd = 1'b0;
				res.load_strobe = 1'b1;
				res.load_byte = command_byte;
			end
		end else begin
			case (cur.phase)
				PH_CMD: begin
					if (shift_flag) begin
						res.flag_clear = 1'b1;
						nxt.phase = PH_REPLY;
						nxt.tick = '0;
						nxt.kept = '0;
						nxt.odd = 1'b0;
					end else if (expired) begin
						nxt.phase = PH_IDLE;
						nxt.tick = '0;
						nxt.odd = 1'b0;
						res.done_res = 1'b1;
						res.timed_out = 1'b1;
					end else begin
						nxt.tick = tick_inc[TICK_W-1:0];
					end
				end
				PH_REPLY: begin
					if (!shift_flag) begin
						if (expired) begin
							nxt.phase = PH_IDLE;
							nxt.tick = '0;
							nxt.odd = 1'b0;
							res.done_res = 1'b1;
							res.reply_count = cur.kept;
							res.timed_out = 1'b1;
						end else begin
							nxt.tick = tick_inc[TICK_W-1:0];
						end
					end else begin
						res.flag_clear = 1'b1;
						nxt.tick = '0;
						if (!xcvr_line) begin
							// device released the line: the byte is not kept
							nxt.phase = PH_IDLE;
							nxt.odd = 1'b0;
							res.done_res = 1'b1;
							res.reply_count = cur.kept;
						end else begin
							if (cur.kept < cap) begin
								res.reply_valid = 1'b1;
								res.reply_byte = shift_in_byte;
								nxt.kept = cur.kept + {{(KEPT_W-1){1'b0}}, 1'b1};
							end
							nxt.odd = ~cur.odd;
						end
					end
				end
				PH_IDLE: begin
				end
				default: begin
					nxt.phase = PH_IDLE;
				end
			endcase
		end

		// lines follow the state left behind by this item
		case (nxt.phase)
			PH_CMD: begin
				res.state_lines = LINES_CMD;
				res.shift_out_mode = 1'b1;
			end
			PH_REPLY: begin
				res.state_lines = nxt.odd ? LINES_ODD : LINES_EVEN;
				res.shift_out_mode = 1'b0;
			end
			default: begin
				res.state_lines = LINES_IDLE;
				res.shift_out_mode = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/core/adb_host_transaction_sequencer.sv @@
// Host-side sequencer for one bus Talk transaction driven through a byte
// shift register.
// Input stream: tuser = req_type (0 start, 1 poll tick); tdata carries the
// command byte, shift-done flag, transceiver line and shifted-in byte.
// Output stream: one result item per input item, with the bus state lines,
// shift direction, load strobe/byte, flag clear, reply byte and the
// done/count/timeout summary when the transaction ends.
// Latency: the result of an item is presented on m_axis the cycle after it
// is accepted. Throughput: one item per cycle unless m_axis stalls; the whole
// state update is a single compare/increment path into the state and result regs.
// Stall: the result register holds while m_axis_tready is low; s_axis_tready
// stays high as long as the result register is empty or being drained.
// Reset: phase idle, counters cleared, timeout_limit = 100000,
// max_reply = 4, output register empty.
// Config: cfg_we writes cfg_wdata to register cfg_addr (0 timeout_limit,
// 1 max_reply); write only while no result is pending.
`default_nettype none
module adb_host_transaction_sequencer
	import adbseq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,

	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// [7:0] command_byte, [8] shift_flag, [9] xcvr_line, [17:10] shift_in_byte,
	// [23:18] zero
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// [0] req_type
	input  logic s_axis_tuser,

	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [1:0] state_lines, [2] shift_out_mode, [3] load_strobe, [11:4] load_byte,
	// [12] flag_clear, [13] reply_valid, [21:14] reply_byte, [22] done_res,
	// [26:23] reply_count, [27] timed_out, [31:28] zero
	output logic [M_TDATA_W-1:0] m_axis_tdata,

	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [TICK_W-1:0] timeout_limit_q;
	logic [KEPT_W-1:0] max_reply_q;
	seq_state_t state_q;
	seq_state_t state_nxt;
	seq_result_t step_res;
	seq_result_t res_q;
	logic res_valid_q;
	logic in_accept;

	assign s_axis_tready = !res_valid_q || m_axis_tready;
	assign in_accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_limit_q <= TIMEOUT_RESET;
			max_reply_q <= MAX_REPLY_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_TIMEOUT_LIMIT: timeout_limit_q <= cfg_wdata[TICK_W-1:0];
				CFG_MAX_REPLY: max_reply_q <= cfg_wdata[KEPT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	adbseq_step u_step (
		.cur(state_q),
		.req_type(s_axis_tuser),
		.command_byte(s_axis_tdata[7:0]),
		.shift_flag(s_axis_tdata[8]),
		.xcvr_line(s_axis_tdata[9]),
		.shift_in_byte(s_axis_tdata[17:10]),
		.timeout_limit(timeout_limit_q),
		.max_reply(max_reply_q),
		.nxt(state_nxt),
		.res(step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, tick: '0, kept: '0, odd: 1'b0};
			res_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				state_q <= state_nxt;
				res_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_q <= step_res;
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata = {{(M_TDATA_W - $bits(seq_result_t)){1'b0}}, res_q};

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> m_axis_tvalid)
		else $error("accepted item produced no result");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_IDLE) |-> (state_q.tick == '0 && !state_q.odd))
		else $error("idle phase with live tick counter or odd phase");

	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.kept <= MAX_REPLY_BYTES)
		else $error("kept count above reply limit");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res_q.done_res) |-> (res_q.state_lines == LINES_IDLE))
		else $error("done reported with lines not idle");

endmodule
`default_nettype wire
